### hw/rtl/pbs_pkg.sv
`default_nettype none
package pbs_pkg;

  // sizing
  localparam int SETTING_STEPS = 8;
  localparam int SAMPLE_BYTES  = 6;
  localparam int NUM_CFG       = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int PHASE_W       = 4;
  localparam int STEP_W        = 3;

  // event codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_IRQ   = 2'd2;
  localparam logic [1:0] OP_DONE  = 2'd3;

  // sequencer phases
  localparam logic [PHASE_W-1:0] PH_IDLE   = 4'd0;
  localparam logic [PHASE_W-1:0] PH_RESET  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_PART   = 4'd2;
  localparam logic [PHASE_W-1:0] PH_WRCFG  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_RDCFG  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_STATUS = 4'd5;
  localparam logic [PHASE_W-1:0] PH_RDPTR  = 4'd6;
  localparam logic [PHASE_W-1:0] PH_WRPTR  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_DATA   = 4'd8;
  localparam logic [PHASE_W-1:0] PH_STOP   = 4'd9;

  // sensor register map
  localparam logic [7:0] REG_INT_STATUS = 8'h00;
  localparam logic [7:0] REG_FIFO_WR    = 8'h04;
  localparam logic [7:0] REG_FIFO_RD    = 8'h06;
  localparam logic [7:0] REG_FIFO_DATA  = 8'h07;
  localparam logic [7:0] REG_MODE       = 8'h09;
  localparam logic [7:0] REG_PART_ID    = 8'hFF;
  localparam logic [7:0] MODE_RESET     = 8'h40;
  localparam logic [7:0] PART_ID        = 8'h15;

  localparam logic [2:0] LEN_WRITE  = 3'd0;
  localparam logic [2:0] LEN_REG    = 3'd1;
  localparam logic [2:0] LEN_SAMPLE = 3'(SAMPLE_BYTES);

  typedef struct packed {
    logic [1:0]  op;
    logic        irq;
    logic [2:0]  rx_len;
    logic [47:0] rx_bytes;
  } pbs_item_t;

  typedef struct packed {
    logic        bus_request;
    logic        bus_is_read;
    logic [7:0]  bus_register;
    logic [7:0]  bus_write_data;
    logic [2:0]  bus_read_length;
    logic        sample_valid;
    logic [23:0] red_sample;
    logic [23:0] ir_sample;
    logic        configured;
    logic        error_code;
    logic        transfer_pending;
  } pbs_result_t;

  function automatic logic [7:0] cfg_addr(input logic [CFG_IDX_W-1:0] idx);
    logic [7:0] a;
    case (idx)
      3'd0:    a = 8'h08;
      3'd1:    a = 8'h0A;
      3'd2:    a = 8'h09;
      3'd3:    a = 8'h0C;
      3'd4:    a = 8'h0D;
      3'd5:    a = 8'h10;
      3'd6:    a = 8'h11;
      default: a = 8'h02;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] cfg_reset(input logic [CFG_IDX_W-1:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'd95;
      3'd1:    v = 8'd111;
      3'd2:    v = 8'd7;
      3'd3:    v = 8'd50;
      3'd4:    v = 8'd50;
      3'd5:    v = 8'd50;
      3'd6:    v = 8'd33;
      default: v = 8'd128;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/pbs_cfg_regs.sv
`default_nettype none
module pbs_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [pbs_pkg::CFG_IDX_W-1:0]  wr_idx,
  input  wire logic [7:0]                     wr_data,
  input  wire logic [pbs_pkg::CFG_IDX_W-1:0]  rd_idx,
  output logic [7:0]                          rd_data
);
  import pbs_pkg::*;

  logic [7:0] setting_r [NUM_CFG];

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CFG; i++) begin
      if (!rst_n) begin
        setting_r[i] <= cfg_reset(CFG_IDX_W'(i));
      end else if (wr_en && wr_idx == CFG_IDX_W'(i)) begin
        setting_r[i] <= wr_data;
      end
    end
  end

  assign rd_data = setting_r[rd_idx];

endmodule
`default_nettype wire

### hw/rtl/pbs_seq_core.sv
`default_nettype none
module pbs_seq_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          advance,
  input  wire pbs_pkg::pbs_item_t            item,
  input  wire logic [7:0]                    setting,
  output logic [pbs_pkg::CFG_IDX_W-1:0]      setting_idx,
  output pbs_pkg::pbs_result_t               result
);
  import pbs_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               configured_r, configured_nxt;
  logic               pending_r, pending_nxt;
  logic               error_r, error_nxt;
  logic [7:0]         rd_index_r, rd_index_nxt;

  logic [STEP_W-1:0]  step_inc;
  logic               more_steps;
  logic [7:0]         b0;
  logic [4:0]         avail;

  // request fields
  logic               req, rd;
  logic [7:0]         addr, wdata;
  logic [2:0]         rlen;

  assign step_inc   = step_r + STEP_W'(1);
  assign more_steps = (step_inc != '0) && ({1'b0, step_inc} < 4'(SETTING_STEPS));
  assign b0         = item.rx_bytes[47:40];
  assign avail      = b0[4:0] - rd_index_r[4:0];
  // setting for the next config write: first one from the part check, later from step_inc
  assign setting_idx = (phase_r == PH_PART) ? '0 : step_inc;

  always_comb begin
    phase_nxt      = phase_r;
    step_nxt       = step_r;
    configured_nxt = configured_r;
    pending_nxt    = pending_r;
    error_nxt      = error_r;
    rd_index_nxt   = rd_index_r;
    req   = 1'b0;
    rd    = 1'b0;
    addr  = '0;
    wdata = '0;
    rlen  = LEN_WRITE;
    result = '0;

    unique case (item.op)
      OP_START: begin
        phase_nxt = PH_RESET;
        req = 1'b1; addr = REG_MODE; wdata = MODE_RESET;
      end
      OP_STOP: begin
        phase_nxt = PH_STOP;
      end
      OP_IRQ: begin
        if (configured_r && !pending_r) begin
          if (item.irq) begin
            phase_nxt = PH_STATUS;
            req = 1'b1; rd = 1'b1; addr = REG_INT_STATUS; rlen = LEN_REG;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: begin // transfer done
        pending_nxt = 1'b0;
        unique case (phase_r)
          PH_RESET: begin
            phase_nxt = PH_PART;
            req = 1'b1; rd = 1'b1; addr = REG_PART_ID; rlen = LEN_REG;
          end
          PH_PART: begin
            if (item.rx_len == LEN_REG && b0 == PART_ID) begin
              phase_nxt = PH_WRCFG;
              step_nxt  = '0;
              req = 1'b1; addr = cfg_addr('0); wdata = setting;
            end else begin
              error_nxt = 1'b1;
              phase_nxt = PH_STOP;
            end
          end
          PH_WRCFG: begin
            if (more_steps) begin
              step_nxt = step_inc;
              req = 1'b1; addr = cfg_addr(step_inc); wdata = setting;
            end else begin
              phase_nxt = PH_RDCFG;
              step_nxt  = '0;
              req = 1'b1; rd = 1'b1; addr = cfg_addr('0); rlen = LEN_REG;
            end
          end
          PH_RDCFG: begin
            if (more_steps) begin
              step_nxt = step_inc;
              req = 1'b1; rd = 1'b1; addr = cfg_addr(step_inc); rlen = LEN_REG;
            end else begin
              phase_nxt      = PH_IDLE;
              step_nxt       = '0;
              configured_nxt = 1'b1;
            end
          end
          PH_STATUS: begin
            phase_nxt = PH_RDPTR;
            req = 1'b1; rd = 1'b1; addr = REG_FIFO_RD; rlen = LEN_REG;
          end
          PH_RDPTR: begin
            if (item.rx_len == LEN_REG) rd_index_nxt = b0;
            phase_nxt = PH_WRPTR;
            req = 1'b1; rd = 1'b1; addr = REG_FIFO_WR; rlen = LEN_REG;
          end
          PH_WRPTR: begin
            if (item.rx_len == LEN_REG) begin
              if (avail != '0) begin
                phase_nxt = PH_DATA;
                req = 1'b1; rd = 1'b1; addr = REG_FIFO_DATA; rlen = LEN_SAMPLE;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
          end
          PH_DATA: begin
            if (item.rx_len == LEN_SAMPLE) begin
              result.sample_valid = 1'b1;
              result.red_sample   = item.rx_bytes[47:24];
              result.ir_sample    = item.rx_bytes[23:0];
              phase_nxt = PH_STATUS;
              req = 1'b1; rd = 1'b1; addr = REG_INT_STATUS; rlen = LEN_REG;
            end
          end
          default: ; // idle, stopped and unused codes
        endcase
      end
    endcase

    if (req) pending_nxt = 1'b1;

    result.bus_request      = req;
    result.bus_is_read      = rd;
    result.bus_register     = addr;
    result.bus_write_data   = wdata;
    result.bus_read_length  = rlen;
    result.configured       = configured_nxt;
    result.error_code       = error_nxt;
    result.transfer_pending = pending_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      step_r       <= '0;
      configured_r <= 1'b0;
      pending_r    <= 1'b0;
      error_r      <= 1'b0;
      rd_index_r   <= '0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      step_r       <= step_nxt;
      configured_r <= configured_nxt;
      pending_r    <= pending_nxt;
      error_r      <= error_nxt;
      rd_index_r   <= rd_index_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ppg_sensor_bus_sequencer_unit.sv
`default_nettype none
// Register-bus sequencer for a two-LED pulse-oximeter sensor.
// in_*  : one event request per handshake. in_tuser carries the event kind
//         (start, stop, interrupt check, transfer done); in_tdata carries the
//         interrupt line level and the bytes returned by a finished transfer.
// out_* : exactly one result request per event: the bus transfer to issue
//         (if any), a delivered red/IR sample (if any) and the status flags
//         configured, error_code and transfer_pending after the event.
// cfg_* : write-only port for the eight setting bytes; write only while idle.
// Path:    an event accepted into the input register is decoded and lands
//         in the output register when that register is free or draining;
//         out_tvalid rises as it lands.
// Throughput: one event per cycle when not stalled; the sequencer state
//         updates as each event moves from the input to the output register.
// Stall: while out_tready is low the result holds, the input register keeps
//         one more event, and in_tready drops once both are full.
// Reset (rst_n low, synchronous): phase idle, flags cleared, both pipeline
//         registers empty, settings back to their default values.
module ppg_sensor_bus_sequencer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input events
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [1:0]                    in_tuser,  // [1:0] operation
  // [0] irq_asserted, [3:1] rx_length, [51:4] rx_bytes, [55:52] zero
  input  wire logic [55:0]                   in_tdata,
  // results
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [0] bus_request, [1] bus_is_read, [9:2] bus_register, [17:10] bus_write_data,
  // [20:18] bus_read_length, [21] sample_valid, [45:22] red_sample,
  // [69:46] ir_sample, [70] configured, [71] error_code, [72] transfer_pending,
  // [79:73] zero
  output logic [79:0]                        out_tdata,
  // settings
  input  wire logic                          cfg_we,
  input  wire logic [pbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_wdata
);
  import pbs_pkg::*;

  logic          item_valid_r;
  pbs_item_t     item_r;
  logic          advance;
  logic          out_valid_r;
  pbs_result_t   res_r;
  pbs_result_t   res_comb;
  logic [CFG_IDX_W-1:0] set_idx;
  logic [7:0]    set_data;

  // event moves on when the output register is free or being drained
  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.op       <= in_tuser;
      item_r.irq      <= in_tdata[0];
      item_r.rx_len   <= in_tdata[3:1];
      item_r.rx_bytes <= in_tdata[51:4];
    end
  end

  pbs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_we),
    .wr_idx  (cfg_index),
    .wr_data (cfg_wdata),
    .rd_idx  (set_idx),
    .rd_data (set_data)
  );

  pbs_seq_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .item        (item_r),
    .setting     (set_data),
    .setting_idx (set_idx),
    .result      (res_comb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_r <= res_comb;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0,
                       res_r.transfer_pending,
                       res_r.error_code,
                       res_r.configured,
                       res_r.ir_sample,
                       res_r.red_sample,
                       res_r.sample_valid,
                       res_r.bus_read_length,
                       res_r.bus_write_data,
                       res_r.bus_register,
                       res_r.bus_is_read,
                       res_r.bus_request};

endmodule
`default_nettype wire
